// ===== rtl/wbmm_pkg.sv =====
// Shared types and constants of the waveform bucket min/max block.
// Used by wbmm_ctrl, wbmm_dp and waveform_bucket_min_max; depends on nothing.
package wbmm_pkg;

  localparam int FRAME_W     = 24;
  localparam int BUCKET_W    = 16;
  localparam int CHAN_CFG_W  = 4;
  localparam int RATE_W      = 20;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CHAN_IDX_W  = 3;
  localparam int STATUS_W    = 2;
  localparam int RES_CNT_W   = 7;
  localparam int MAX_RESULTS = 64;
  localparam int DIV_CNT_W   = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_BUCKETS = 2'd1,
    ST_BAD_BUFFER  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT   = 2'd0,
    REG_BUCKET_COUNT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_SAMPLE_RATE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_INIT,
    S_LOAD,
    S_EMIT,
    S_DONE,
    S_ERR
  } state_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic restart;
    logic load;
    logic emit;
    logic commit;
    logic err_out;
  } cmd_t;

  typedef struct packed {
    status_t cfg_status;
    logic    cfg_written;
    logic    div_last;
    logic    close_now;
    logic    final_result;
    logic    out_free;
  } stat_t;

endpackage

// ===== rtl/wbmm_ctrl.sv =====
// Sequencer of the waveform bucket min/max block: divider, per-beat load,
// result emission and commit. Depends on wbmm_pkg.
module wbmm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wbmm_pkg::stat_t stat,
  output wbmm_pkg::cmd_t  cmd
);

  wbmm_pkg::state_t state_r;
  wbmm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wbmm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (stat.cfg_written) begin
      state_nxt = wbmm_pkg::S_DIV;
    end else begin
      unique case (state_r)
        wbmm_pkg::S_IDLE: begin
          if (in_valid) begin
            if (stat.cfg_status != wbmm_pkg::ST_OK) state_nxt = wbmm_pkg::S_ERR;
            else state_nxt = wbmm_pkg::S_LOAD;
          end
        end
        wbmm_pkg::S_DIV: begin
          if (stat.div_last) state_nxt = wbmm_pkg::S_INIT;
        end
        wbmm_pkg::S_INIT: state_nxt = wbmm_pkg::S_IDLE;
        wbmm_pkg::S_LOAD: state_nxt = wbmm_pkg::S_EMIT;
        wbmm_pkg::S_EMIT: begin
          if (!stat.close_now) begin
            state_nxt = wbmm_pkg::S_DONE;
          end else if (stat.out_free && stat.final_result) begin
            state_nxt = wbmm_pkg::S_DONE;
          end
        end
        wbmm_pkg::S_DONE: state_nxt = wbmm_pkg::S_IDLE;
        wbmm_pkg::S_ERR: begin
          if (stat.out_free) state_nxt = wbmm_pkg::S_IDLE;
        end
        default: state_nxt = wbmm_pkg::S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      wbmm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      wbmm_pkg::S_DIV:  cmd.div_step = 1'b1;
      wbmm_pkg::S_INIT: cmd.restart  = 1'b1;
      wbmm_pkg::S_LOAD: cmd.load     = 1'b1;
      wbmm_pkg::S_EMIT: cmd.emit     = stat.close_now && stat.out_free;
      wbmm_pkg::S_DONE: cmd.commit   = 1'b1;
      wbmm_pkg::S_ERR:  cmd.err_out  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/wbmm_dp.sv =====
// Datapath of the waveform bucket min/max block: configuration registers,
// frame/bucket divider, bucket bounds, running min/max and result register.
// Depends on wbmm_pkg.
module wbmm_dp #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wbmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wbmm_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [wbmm_pkg::STATUS_W-1:0]        out_status,
  output logic [wbmm_pkg::BUCKET_W-1:0]        out_bucket_index,
  output logic [wbmm_pkg::CHAN_IDX_W-1:0]      out_channel_index,
  output logic signed [SAMPLE_BITS-1:0]        out_minimum,
  output logic signed [SAMPLE_BITS-1:0]        out_maximum,
  output logic                                 out_last,
  input  wbmm_pkg::cmd_t                       cmd,
  output wbmm_pkg::stat_t                      stat
);

  localparam int FW  = wbmm_pkg::FRAME_W;
  localparam int BW  = wbmm_pkg::BUCKET_W;
  localparam int CW  = wbmm_pkg::CHAN_CFG_W;
  localparam int RW  = wbmm_pkg::RATE_W;
  localparam int CIW = wbmm_pkg::CHAN_IDX_W;
  localparam int NW  = wbmm_pkg::RES_CNT_W;
  localparam int DW  = wbmm_pkg::DIV_CNT_W;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W = 6;
  localparam logic [CMP_W-1:0] MAXC  = CMP_W'(MAX_CHANNELS);
  localparam logic [NW-1:0]    NLAST = NW'(wbmm_pkg::MAX_RESULTS - 1);

  // configuration
  logic [FW-1:0] frame_count_r;
  logic [BW-1:0] bucket_count_r;
  logic [CW-1:0] channel_count_r;
  logic [RW-1:0] sample_rate_r;

  // divider: frame_count / bucket_count
  logic [DW-1:0] div_cnt_r;
  logic [BW-1:0] div_rem_r;
  logic [FW-1:0] qf_r;
  logic [DW-1:0] div_idx;
  logic [BW:0]   div_trial;
  logic          div_ge;

  // committed position
  logic [BW-1:0]   cur_k_r;
  logic [FW-1:0]   cur_begin_r;
  logic [FW-1:0]   cur_end_r;
  logic [BW-1:0]   cur_rem_r;
  logic [FW-1:0]   frame_r;
  logic [CH_W-1:0] chan_r;

  // walk over the buckets closed by this beat
  logic [BW:0]   it_k_r;
  logic [FW-1:0] it_begin_r;
  logic [FW-1:0] it_end_r;
  logic [BW-1:0] it_rem_r;
  logic [FW-1:0] nx_end_r;
  logic [BW-1:0] nx_rem_r;
  logic [NW-1:0] n_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  logic signed [SAMPLE_BITS-1:0] run_min_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] run_max_r [MAX_CHANNELS];

  logic                          out_valid_r;
  logic [wbmm_pkg::STATUS_W-1:0] out_status_r;
  logic [BW-1:0]                 out_bucket_r;
  logic [CIW-1:0]                out_chan_r;
  logic signed [SAMPLE_BITS-1:0] out_min_r;
  logic signed [SAMPLE_BITS-1:0] out_max_r;
  logic                          out_last_r;

  wbmm_pkg::status_t cfg_status;
  logic [FW+5-1:0]   f_times32;
  logic [FW:0]       fp1;
  logic [FW-1:0]     fnext;
  logic              close_k;
  logic              close_k1;
  logic              final_res;
  logic              out_free;
  logic              first_frame;
  logic              last_chan;
  logic              wrap;
  logic signed [SAMPLE_BITS-1:0] rd_min;
  logic signed [SAMPLE_BITS-1:0] rd_max;
  logic [BW:0]       step_sum_ld;
  logic              step_c_ld;
  logic [BW:0]       step_sum_nx;
  logic              step_c_nx;

  always_comb begin
    f_times32 = {frame_count_r, 5'b0};
    if (bucket_count_r == '0) begin
      cfg_status = wbmm_pkg::ST_BAD_BUCKETS;
    end else if (sample_rate_r == '0 || channel_count_r == '0 || frame_count_r == '0 ||
                 {2'b0, channel_count_r} > MAXC) begin
      cfg_status = wbmm_pkg::ST_BAD_BUFFER;
    end else if ((FW+5)'(bucket_count_r) > f_times32) begin
      cfg_status = wbmm_pkg::ST_BAD_BUCKETS;
    end else begin
      cfg_status = wbmm_pkg::ST_OK;
    end
  end

  always_comb begin
    div_idx   = div_cnt_r - DW'(1);
    div_trial = {div_rem_r, frame_count_r[div_idx]};
    div_ge    = div_trial >= {1'b0, bucket_count_r};
  end

  always_comb begin
    step_sum_ld = {1'b0, cur_rem_r} + {1'b0, div_rem_r};
    step_c_ld   = step_sum_ld >= {1'b0, bucket_count_r};
    step_sum_nx = {1'b0, nx_rem_r} + {1'b0, div_rem_r};
    step_c_nx   = step_sum_nx >= {1'b0, bucket_count_r};
  end

  always_comb begin
    fp1   = {1'b0, frame_r} + (FW+1)'(1);
    fnext = fp1[FW-1:0];
    close_k = (it_k_r < {1'b0, bucket_count_r}) &&
              ((it_end_r > it_begin_r) ? ({1'b0, it_end_r} == fp1) : (it_begin_r == frame_r));
    close_k1 = ((it_k_r + (BW+1)'(1)) < {1'b0, bucket_count_r}) &&
               ((nx_end_r > it_end_r) ? ({1'b0, nx_end_r} == fp1) : (it_end_r == frame_r));
    final_res   = !close_k1 || (n_r == NLAST);
    out_free    = !out_valid_r || !out_stall;
    first_frame = frame_r == cur_begin_r;
    last_chan   = (CMP_W'(chan_r) + CMP_W'(1)) >= CMP_W'(channel_count_r);
    wrap        = ({1'b0, fnext} >= {1'b0, frame_count_r}) ||
                  (it_k_r >= {1'b0, bucket_count_r}) || (fnext == '0);
    rd_min      = run_min_r[chan_r];
    rd_max      = run_max_r[chan_r];
  end

  always_comb begin
    stat.cfg_status   = cfg_status;
    stat.cfg_written  = cfg_wr_en;
    stat.div_last     = div_cnt_r == DW'(1);
    stat.close_now    = close_k;
    stat.final_result = final_res;
    stat.out_free     = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= '0;
      bucket_count_r  <= '0;
      channel_count_r <= '0;
      sample_rate_r   <= '0;
      div_cnt_r       <= '0;
      cur_k_r         <= '0;
      cur_begin_r     <= '0;
      cur_end_r       <= '0;
      cur_rem_r       <= '0;
      frame_r         <= '0;
      chan_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (wbmm_pkg::cfg_reg_t'(cfg_index))
          wbmm_pkg::REG_FRAME_COUNT:   frame_count_r   <= cfg_wdata[FW-1:0];
          wbmm_pkg::REG_BUCKET_COUNT:  bucket_count_r  <= cfg_wdata[BW-1:0];
          wbmm_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CW-1:0];
          wbmm_pkg::REG_SAMPLE_RATE:   sample_rate_r   <= cfg_wdata[RW-1:0];
          default: ;
        endcase
        div_cnt_r <= DW'(FW);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - DW'(1);
      end

      if (cmd.restart) begin
        cur_k_r     <= '0;
        cur_begin_r <= '0;
        cur_end_r   <= qf_r;
        cur_rem_r   <= div_rem_r;
        frame_r     <= '0;
        chan_r      <= '0;
      end else if (cmd.commit) begin
        if (last_chan) begin
          chan_r <= '0;
          if (wrap) begin
            cur_k_r     <= '0;
            cur_begin_r <= '0;
            cur_end_r   <= qf_r;
            cur_rem_r   <= div_rem_r;
            frame_r     <= '0;
          end else begin
            cur_k_r     <= it_k_r[BW-1:0];
            cur_begin_r <= it_begin_r;
            cur_end_r   <= it_end_r;
            cur_rem_r   <= it_rem_r;
            frame_r     <= fnext;
          end
        end else begin
          chan_r <= chan_r + CH_W'(1);
        end
      end

      if (cmd.emit || cmd.err_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cfg_wr_en) begin
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? BW'(div_trial - {1'b0, bucket_count_r}) : div_trial[BW-1:0];
      qf_r      <= {qf_r[FW-2:0], div_ge};
    end

    if (cmd.take) begin
      sample_r <= in_sample;
    end

    if (cmd.load) begin
      if (first_frame) begin
        run_min_r[chan_r] <= sample_r;
        run_max_r[chan_r] <= sample_r;
      end else begin
        if (sample_r < rd_min) run_min_r[chan_r] <= sample_r;
        if (sample_r > rd_max) run_max_r[chan_r] <= sample_r;
      end
      it_k_r     <= {1'b0, cur_k_r};
      it_begin_r <= cur_begin_r;
      it_end_r   <= cur_end_r;
      it_rem_r   <= cur_rem_r;
      nx_end_r   <= cur_end_r + qf_r + FW'(step_c_ld);
      nx_rem_r   <= step_c_ld ? BW'(step_sum_ld - {1'b0, bucket_count_r}) : step_sum_ld[BW-1:0];
      n_r        <= '0;
    end else if (cmd.emit) begin
      it_k_r     <= it_k_r + (BW+1)'(1);
      it_begin_r <= it_end_r;
      it_end_r   <= nx_end_r;
      it_rem_r   <= nx_rem_r;
      nx_end_r   <= nx_end_r + qf_r + FW'(step_c_nx);
      nx_rem_r   <= step_c_nx ? BW'(step_sum_nx - {1'b0, bucket_count_r}) : step_sum_nx[BW-1:0];
      n_r        <= n_r + NW'(1);
    end

    if (cmd.emit) begin
      out_status_r <= wbmm_pkg::ST_OK;
      out_bucket_r <= it_k_r[BW-1:0];
      out_chan_r   <= CIW'(chan_r);
      out_min_r    <= (n_r == '0) ? rd_min : sample_r;
      out_max_r    <= (n_r == '0) ? rd_max : sample_r;
      out_last_r   <= final_res;
    end else if (cmd.err_out) begin
      out_status_r <= cfg_status;
      out_bucket_r <= '0;
      out_chan_r   <= '0;
      out_min_r    <= '0;
      out_max_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_bucket_index  = out_bucket_r;
  assign out_channel_index = out_chan_r;
  assign out_minimum       = out_min_r;
  assign out_maximum       = out_max_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/waveform_bucket_min_max.sv =====
// Top level of the waveform bucket min/max block: joins wbmm_ctrl and wbmm_dp.
// Depends on wbmm_pkg.
//
// Interleaved samples enter on the in_ channel, one beat per channel sample,
// frame by frame. The frames are split into bucket_count buckets; when the
// sample of a channel in a bucket's last frame arrives, one result beat per
// closed bucket leaves on the out_ channel with that channel's min and max,
// out_last high on the final beat caused by the input. A bad configuration
// gives one status beat per input instead. Each input beat passes the
// take, load, emission and commit steps in turn, and no new input is
// taken before its commit; the emission step registers its results one a
// cycle while the receiver is free. The next input is taken while a result
// still waits in the output register; a stalled receiver holds the emission
// step. A configuration write restarts the clip and runs the frames-per-
// bucket divider, one quotient bit a cycle, while in_stall stays high.
// Reset clears configuration and position and leaves the block idle.
module waveform_bucket_min_max #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wbmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wbmm_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wbmm_pkg::STATUS_W-1:0]        out_status,
  output logic [wbmm_pkg::BUCKET_W-1:0]        out_bucket_index,
  output logic [wbmm_pkg::CHAN_IDX_W-1:0]      out_channel_index,
  output logic signed [SAMPLE_BITS-1:0]        out_minimum,
  output logic signed [SAMPLE_BITS-1:0]        out_maximum,
  output logic                                 out_last
);

  wbmm_pkg::cmd_t  cmd;
  wbmm_pkg::stat_t stat;

  wbmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wbmm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sample         (in_sample),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_bucket_index  (out_bucket_index),
    .out_channel_index (out_channel_index),
    .out_minimum       (out_minimum),
    .out_maximum       (out_maximum),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

// ===== sim/waveform_bucket_min_max_tb.sv =====
// Testbench for waveform_bucket_min_max: drives interleaved samples over several
// bucket configurations and checks every min/max range beat against its own predictor.
// Depends on wbmm_pkg and the waveform_bucket_min_max RTL; reads no files.
module waveform_bucket_min_max_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = 24;
  localparam int CHANNELS     = 8;
  localparam int RANDOM_ITEMS = 240;
  localparam int SETTLE       = 32;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    wbmm_pkg::status_t                     status;
    logic [wbmm_pkg::BUCKET_W-1:0]         bucket;
    logic [wbmm_pkg::CHAN_IDX_W-1:0]       chan;
    logic signed [SAMPLE_W-1:0]            lo;
    logic signed [SAMPLE_W-1:0]            hi;
    logic                                  last;
  } bucket_range_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  cfg_wr_en = 1'b0;
  logic [wbmm_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [wbmm_pkg::CFG_W-1:0]            cfg_wdata = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic signed [SAMPLE_W-1:0]            in_sample = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic [wbmm_pkg::STATUS_W-1:0]         out_status;
  logic [wbmm_pkg::BUCKET_W-1:0]         out_bucket_index;
  logic [wbmm_pkg::CHAN_IDX_W-1:0]       out_channel_index;
  logic signed [SAMPLE_W-1:0]            out_minimum;
  logic signed [SAMPLE_W-1:0]            out_maximum;
  logic                                  out_last;

  bucket_range_t ranges_q[$];
  int unsigned   mismatches = 0;
  int unsigned   samples_sent = 0;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;

  // predictor state
  logic [wbmm_pkg::FRAME_W-1:0]          frames_cfg;
  logic [wbmm_pkg::BUCKET_W-1:0]         buckets_cfg;
  logic [wbmm_pkg::CHAN_CFG_W-1:0]       chans_cfg;
  logic [wbmm_pkg::RATE_W-1:0]           rate_cfg;
  logic signed [SAMPLE_W-1:0]            run_lo [CHANNELS];
  logic signed [SAMPLE_W-1:0]            run_hi [CHANNELS];
  logic [wbmm_pkg::FRAME_W-1:0]          frame_pos;
  int unsigned                           chan_pos;
  logic [wbmm_pkg::BUCKET_W-1:0]         open_bucket;

  waveform_bucket_min_max #(
    .MAX_CHANNELS(CHANNELS),
    .SAMPLE_BITS (SAMPLE_W)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_bucket_index (out_bucket_index),
    .out_channel_index(out_channel_index),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_last         (out_last)
  );

  always #2 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned first_frame(input longint unsigned k);
    if (buckets_cfg == 0) return 0;
    return (k * frames_cfg) / buckets_cfg;
  endfunction

  function automatic longint unsigned last_frame(input longint unsigned k);
    longint unsigned b, e;
    if (buckets_cfg == 0) return 0;
    b = (k * frames_cfg) / buckets_cfg;
    e = ((k + 1) * frames_cfg) / buckets_cfg;
    return (e > b) ? e - 1 : b;
  endfunction

  function automatic wbmm_pkg::status_t cfg_status();
    longint unsigned limit;
    limit = 32 * longint'(frames_cfg);
    if (buckets_cfg == 0) return wbmm_pkg::ST_BAD_BUCKETS;
    if (rate_cfg == 0 || chans_cfg == 0 || frames_cfg == 0 || chans_cfg > CHANNELS)
      return wbmm_pkg::ST_BAD_BUFFER;
    if (longint'(buckets_cfg) > limit) return wbmm_pkg::ST_BAD_BUCKETS;
    return wbmm_pkg::ST_OK;
  endfunction

  function automatic void restart_clip();
    frame_pos = '0;
    chan_pos = 0;
    open_bucket = '0;
  endfunction

  function automatic void reset_model();
    frames_cfg = '0;
    buckets_cfg = '0;
    chans_cfg = '0;
    rate_cfg = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      run_lo[i] = '0;
      run_hi[i] = '0;
    end
    restart_clip();
  endfunction

  function automatic void predict_ranges(input logic signed [SAMPLE_W-1:0] s);
    wbmm_pkg::status_t st;
    bucket_range_t     r;
    int unsigned       c, n;
    longint unsigned   k, f;
    st = cfg_status();
    r = '0;
    if (st != wbmm_pkg::ST_OK) begin
      r.status = st;
      r.last = 1'b1;
      ranges_q.push_back(r);
      return;
    end
    c = chan_pos % CHANNELS;
    f = frame_pos;
    if (f == first_frame(open_bucket)) begin
      run_lo[c] = s;
      run_hi[c] = s;
    end else begin
      if (s < run_lo[c]) run_lo[c] = s;
      if (s > run_hi[c]) run_hi[c] = s;
    end
    k = open_bucket;
    n = 0;
    while (k < buckets_cfg && last_frame(k) == f && n < wbmm_pkg::MAX_RESULTS) begin
      r = '0;
      r.status = wbmm_pkg::ST_OK;
      r.bucket = k[wbmm_pkg::BUCKET_W-1:0];
      r.chan = c[wbmm_pkg::CHAN_IDX_W-1:0];
      r.lo = (k == open_bucket) ? run_lo[c] : s;
      r.hi = (k == open_bucket) ? run_hi[c] : s;
      ranges_q.push_back(r);
      n++;
      k++;
    end
    if (n > 0) ranges_q[ranges_q.size()-1].last = 1'b1;
    if (chan_pos + 1 >= chans_cfg) begin
      chan_pos = 0;
      open_bucket = k[wbmm_pkg::BUCKET_W-1:0];
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= frames_cfg || k >= buckets_cfg || frame_pos == 0) restart_clip();
    end else begin
      chan_pos = chan_pos + 1;
    end
  endfunction

  always @(posedge clk) begin : check_ranges
    bucket_range_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ranges_q.size() == 0) begin
        mismatches++;
        $display("%0t: range beat expected none, actual st=%0d bkt=%0d ch=%0d min=%0d max=%0d",
                 $time, out_status, out_bucket_index, out_channel_index,
                 out_minimum, out_maximum);
      end else begin
        want = ranges_q.pop_front();
        if (out_status != want.status || out_bucket_index != want.bucket ||
            out_channel_index != want.chan || out_minimum != want.lo ||
            out_maximum != want.hi || out_last != want.last) begin
          mismatches++;
          $display("%0t: expected st=%0d bkt=%0d ch=%0d min=%0d max=%0d last=%0d",
                   $time, want.status, want.bucket, want.chan, want.lo, want.hi, want.last);
          $display("%0t: actual   st=%0d bkt=%0d ch=%0d min=%0d max=%0d last=%0d",
                   $time, out_status, out_bucket_index, out_channel_index,
                   out_minimum, out_maximum, out_last);
        end
      end
    end
  end

  always @(negedge clk) begin : drive_out_stall
    int unsigned hold_cnt;
    bit          hold_done;
    if (hold_req && !hold_done) begin
      hold_cnt = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else begin
      out_stall = idle_on && ($urandom_range(99) < 9);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(8)) - 24'd4;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    do @(posedge clk); while (in_stall);
    predict_ranges(s);
    samples_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (ranges_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input wbmm_pkg::cfg_reg_t idx,
                           input logic [wbmm_pkg::CFG_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      wbmm_pkg::REG_FRAME_COUNT:   frames_cfg = val[wbmm_pkg::FRAME_W-1:0];
      wbmm_pkg::REG_BUCKET_COUNT:  buckets_cfg = val[wbmm_pkg::BUCKET_W-1:0];
      wbmm_pkg::REG_CHANNEL_COUNT: chans_cfg = val[wbmm_pkg::CHAN_CFG_W-1:0];
      wbmm_pkg::REG_SAMPLE_RATE:   rate_cfg = val[wbmm_pkg::RATE_W-1:0];
      default: ;
    endcase
    restart_clip();
  endtask

  task automatic configure(input logic [wbmm_pkg::FRAME_W-1:0] frames,
                           input logic [wbmm_pkg::BUCKET_W-1:0] buckets,
                           input logic [wbmm_pkg::CHAN_CFG_W-1:0] chans,
                           input logic [wbmm_pkg::RATE_W-1:0] rate_hz);
    write_reg(wbmm_pkg::REG_FRAME_COUNT, frames);
    write_reg(wbmm_pkg::REG_BUCKET_COUNT, {8'($urandom), buckets});
    write_reg(wbmm_pkg::REG_CHANNEL_COUNT, {20'($urandom), chans});
    write_reg(wbmm_pkg::REG_SAMPLE_RATE, {4'($urandom), rate_hz});
  endtask

  task automatic send_clip(input int unsigned beats);
    repeat (beats) send_sample(pick_sample());
  endtask

  task automatic test_bad_config();
    send_sample(24'sh7FFFFF);
    configure(24'd4, 16'd2, 4'd0, 20'd1);
    send_sample(24'sh800000);
    configure(24'd4, 16'd2, 4'd9, 20'd1);
    send_sample(24'sh000000);
    configure(24'd4, 16'd2, 4'd15, 20'd1);
    send_sample(24'shFFFFFF);
    configure(24'd4, 16'd2, 4'd2, 20'd0);
    send_sample(24'sh000001);
    configure(24'd0, 16'd2, 4'd2, 20'd1);
    send_sample(24'sh555555);
    configure(24'd1, 16'd33, 4'd1, 20'hFFFFF);
    send_sample(24'shAAAAAA);
  endtask

  task automatic test_directed();
    configure(24'd3, 16'd2, 4'd2, 20'd48000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000000);
    send_sample(24'shFFFFFF);
    send_sample(24'sh000001);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    configure(24'd1, 16'd32, 4'd8, 20'd44100);
    for (int i = 0; i < CHANNELS; i++) send_sample(i[0] ? 24'sh800000 : 24'sh7FFFFF);
    configure(24'hFFFFFF, 16'hFFFF, 4'd8, 20'hFFFFF);
    send_clip(4);
  endtask

  task automatic test_backpressure();
    configure(24'd2, 16'd64, 4'd8, 20'd1);
    hold_req = 1'b1;
    send_clip(16);
    send_clip(4);
    wait_drained();
    send_clip(12);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    configure(24'd5, 16'd3, 4'd3, 20'd96000);
    send_clip(45);
    configure(24'd4, 16'd9, 4'd1, 20'd8000);
    send_clip(8);
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned stop_at, fr, ch, bk, top;
    stop_at = samples_sent + RANDOM_ITEMS;
    while (samples_sent < stop_at) begin
      case ($urandom_range(19))
        0: begin
          case ($urandom_range(4))
            0: configure(24'($urandom_range(1, 40)), 16'd0, 4'($urandom_range(1, 8)),
                         20'($urandom_range(1, 20'hFFFFF)));
            1: configure(24'd0, 16'($urandom_range(1, 20)), 4'($urandom_range(1, 8)),
                         20'($urandom_range(1, 20'hFFFFF)));
            2: configure(24'($urandom_range(1, 40)), 16'($urandom_range(1, 20)),
                         ($urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15))),
                         20'($urandom_range(1, 20'hFFFFF)));
            3: configure(24'($urandom_range(1, 40)), 16'($urandom_range(1, 20)),
                         4'($urandom_range(1, 8)), 20'd0);
            default: begin
              fr = $urandom_range(1, 100);
              configure(24'(fr), 16'(32 * fr + $urandom_range(1, 100)),
                        4'($urandom_range(1, 8)), 20'($urandom_range(1, 20'hFFFFF)));
            end
          endcase
          send_clip($urandom_range(1, 3));
        end
        1, 2: begin
          fr = $urandom_range(13, 4000);
          top = (32 * fr > 65535) ? 65535 : 32 * fr;
          configure(24'(fr), 16'($urandom_range(1, top)), 4'($urandom_range(1, 8)),
                    20'($urandom_range(1, 20'hFFFFF)));
          send_clip($urandom_range(4, 30));
        end
        default: begin
          fr = $urandom_range(1, 12);
          ch = ($urandom_range(4) == 0) ? 8 : $urandom_range(1, 4);
          case ($urandom_range(3))
            0: bk = $urandom_range(1, fr);
            1: bk = fr;
            2: bk = $urandom_range(fr, 32 * fr);
            default: bk = 32 * fr;
          endcase
          configure(24'(fr), 16'(bk), 4'(ch), 20'($urandom_range(1, 20'hFFFFF)));
          send_clip(fr * ch * $urandom_range(1, 2));
          if ($urandom_range(3) == 0 && fr * ch > 1) send_clip($urandom_range(1, fr * ch - 1));
        end
      endcase
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_bad_config();
    test_directed();
    test_backpressure();
    test_no_idle();
    test_random();
    wait_drained();
    if (mismatches == 0 && ranges_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wbmm_pkg.sv
rtl/wbmm_ctrl.sv
rtl/wbmm_dp.sv
rtl/waveform_bucket_min_max.sv
sim/waveform_bucket_min_max_tb.sv
